// ===== design/bgc_pkg.sv =====
// Package for the button gesture classifier.
// Holds the event codes, config reset values and shared structs; no dependencies.
package bgc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned ThrW  = 16;
    localparam int unsigned ClickW = 2;

    localparam logic [ThrW-1:0] LongPressRst   = 16'd1000;
    localparam logic [ThrW-1:0] DoublePressRst = 16'd300;
    localparam logic [ClickW-1:0] ClicksForDouble = 2'd2;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_SHORT  = 2'd1,
        EVT_LONG   = 2'd2,
        EVT_DOUBLE = 2'd3
    } t_event;

    typedef enum logic {
        REG_LONG_PRESS   = 1'b0,
        REG_DOUBLE_PRESS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [ThrW-1:0] long_thr;
        logic [ThrW-1:0] dbl_thr;
    } t_cfg;

    typedef struct packed {
        t_event evt;
        logic   press_edge;
        logic   release_edge;
    } t_result;

endpackage

// ===== design/bgc_classify.sv =====
// Gesture state registers and the per-sample classification logic.
// Depends on bgc_pkg.
module bgc_classify (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic                    i_is_down,
    input  logic [bgc_pkg::TimeW-1:0] i_now_ms,
    input  bgc_pkg::t_cfg           i_cfg,
    output bgc_pkg::t_result        o_res
);

    logic                          r_held, n_held;
    logic [bgc_pkg::TimeW-1:0]     r_press_start, n_press_start;
    logic [bgc_pkg::TimeW-1:0]     r_last_release, n_last_release;
    logic                          r_long_rep, n_long_rep;
    logic [bgc_pkg::ClickW-1:0]    r_clicks, n_clicks;

    logic [bgc_pkg::TimeW-1:0]     hold_time;
    logic [bgc_pkg::TimeW-1:0]     since_rel;
    logic                          hold_reached;
    logic                          window_over;

    assign hold_time    = i_now_ms - r_press_start;
    assign hold_reached = hold_time >= {{(bgc_pkg::TimeW-bgc_pkg::ThrW){1'b0}},
                                        i_cfg.long_thr};
    assign since_rel    = i_now_ms - n_last_release;
    assign window_over  = since_rel >= {{(bgc_pkg::TimeW-bgc_pkg::ThrW){1'b0}},
                                        i_cfg.dbl_thr};

    always_comb begin
        n_held         = r_held;
        n_press_start  = r_press_start;
        n_last_release = r_last_release;
        n_long_rep     = r_long_rep;
        n_clicks       = r_clicks;
        o_res.evt          = bgc_pkg::EVT_NONE;
        o_res.press_edge   = 1'b0;
        o_res.release_edge = 1'b0;

        if (i_is_down && !r_held) begin
            n_held           = 1'b1;
            n_press_start    = i_now_ms;
            n_long_rep       = 1'b0;
            o_res.press_edge = 1'b1;
        end else if (i_is_down && !r_long_rep && hold_reached) begin
            o_res.evt  = bgc_pkg::EVT_LONG;
            n_long_rep = 1'b1;
            n_clicks   = '0;
        end else if (!i_is_down && r_held) begin
            n_held             = 1'b0;
            o_res.release_edge = 1'b1;
            if (r_long_rep) begin
                n_clicks = '0;
            end else if (!hold_reached) begin
                n_clicks       = r_clicks + 2'd1;
                n_last_release = i_now_ms;
            end
        end

        // pending clicks only resolve while released
        if (!n_held && (n_clicks != '0)) begin
            if (n_clicks == bgc_pkg::ClicksForDouble) begin
                o_res.evt = bgc_pkg::EVT_DOUBLE;
                n_clicks  = '0;
            end else if (window_over) begin
                o_res.evt = bgc_pkg::EVT_SHORT;
                n_clicks  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held         <= 1'b0;
            r_press_start  <= '0;
            r_last_release <= '0;
            r_long_rep     <= 1'b0;
            r_clicks       <= '0;
        end else if (i_advance) begin
            r_held         <= n_held;
            r_press_start  <= n_press_start;
            r_last_release <= n_last_release;
            r_long_rep     <= n_long_rep;
            r_clicks       <= n_clicks;
        end
    end

endmodule

// ===== design/button_gesture_classifier_unit.sv =====
// Top level of the button gesture classifier: sample register, config
// registers and result register. Depends on bgc_pkg and bgc_classify.
// A sample moves from the sample register into the result register, and each
//   register holds its contents while the result channel stalls.
// Throughput: one sample per cycle while the result channel does not stall, set
//   by the sample and result registers; gesture state updates as a sample moves on.
// Reset: synchronous active-low; clears both stages, the gesture state and
//   loads the thresholds with 1000 ms (long) and 300 ms (double).
module button_gesture_classifier_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // sample channel
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_is_down,
    input  logic [bgc_pkg::TimeW-1:0] i_now_ms,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_event_res,
    output logic                      o_press_edge,
    output logic                      o_release_edge,
    // config write port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bgc_pkg::ThrW-1:0]  i_cfg_wdata
);

    bgc_pkg::t_cfg    r_cfg;
    bgc_pkg::t_result calc_res;
    bgc_pkg::t_result r_res;

    logic                      r_in_valid;
    logic                      r_in_down;
    logic [bgc_pkg::TimeW-1:0] r_in_now;
    logic                      out_free;
    logic                      advance;

    // The result register frees up when empty or when its transaction is taken;
    // the sample register advances into it whenever it is free.
    assign out_free   = !o_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    // config registers, to be written by the user only while the block is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_thr <= bgc_pkg::LongPressRst;
            r_cfg.dbl_thr  <= bgc_pkg::DoublePressRst;
        end else if (i_cfg_we) begin
            case (bgc_pkg::t_reg_idx'(i_cfg_index))
                bgc_pkg::REG_LONG_PRESS:   r_cfg.long_thr <= i_cfg_wdata;
                bgc_pkg::REG_DOUBLE_PRESS: r_cfg.dbl_thr  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sample register: hold while the result stage is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_down <= i_is_down;
            r_in_now  <= i_now_ms;
        end
    end

    // classification and gesture state; state advances with the sample
    bgc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_is_down (r_in_down),
        .i_now_ms  (r_in_now),
        .i_cfg     (r_cfg),
        .o_res     (calc_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_free) begin
            o_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= calc_res;
        end
    end

    assign o_event_res    = r_res.evt;
    assign o_press_edge   = r_res.press_edge;
    assign o_release_edge = r_res.release_edge;

    // a stalled sample keeps its slot and its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in_now)
                                       && $stable(r_in_down)))
        else $error("sample register lost a stalled transaction");

    // a press and a release never land on the same sample
    a_edges_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_press_edge && o_release_edge))
        else $error("press and release edge flagged together");

    // a long event is only raised while held, never with an edge
    a_long_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == bgc_pkg::EVT_LONG))
            |-> (!o_press_edge && !o_release_edge))
        else $error("long event raised on an edge sample");

    // short and double only resolve while released, so never on a press edge
    a_click_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_press_edge) |-> (o_event_res == bgc_pkg::EVT_NONE))
        else $error("event raised on a press edge");

endmodule
